@@ rtl/hbd_pkg.sv @@
package hbd_pkg;

  localparam int TAP_COUNT_DEF = 39;
  localparam int BASE_TAPS     = 39;
  localparam int COEF_IDX_W    = 7;
  localparam int SAMPLE_W      = 12;
  localparam int PCM_W         = 16;
  localparam int CODE_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO = 2'd1;

  localparam logic [14:0] ULAW_BIAS = 15'h0084;
  localparam logic [16:0] ULAW_CLIP = 17'd32635;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_op_t;

  localparam logic signed [PCM_W-1:0] COEF_TABLE [0:BASE_TAPS-1] = '{
    -16'sd43, 16'sd0, 16'sd64, 16'sd0, -16'sd123, 16'sd0, 16'sd231, 16'sd0,
    -16'sd405, 16'sd0, 16'sd670, 16'sd0, -16'sd1081, 16'sd0, 16'sd1778, 16'sd0,
    -16'sd3288, 16'sd0, 16'sd10378, 16'sd16405, 16'sd10378, 16'sd0, -16'sd3288,
    16'sd0, 16'sd1778, 16'sd0, -16'sd1081, 16'sd0, 16'sd670, 16'sd0, -16'sd405,
    16'sd0, 16'sd231, 16'sd0, -16'sd123, 16'sd0, 16'sd64, 16'sd0, -16'sd43
  };

  // taps past the base window are zero
  function automatic logic signed [PCM_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
    logic signed [PCM_W-1:0] c;
    c = '0;
    if (idx < COEF_IDX_W'(BASE_TAPS)) c = COEF_TABLE[idx[5:0]];
    return c;
  endfunction

endpackage

@@ rtl/hbd_ram.sv @@
module hbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 39
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ rtl/hbd_mac.sv @@
module hbd_mac
  import hbd_pkg::*;
#(
  parameter int TAP_COUNT = TAP_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_op_t                 op,
  input  logic signed [PCM_W-1:0] sample,
  input  logic signed [PCM_W-1:0] coef,
  output logic                    done,
  output logic signed [PCM_W-1:0] result
);

  localparam int ACC_W = 2 * PCM_W + $clog2(TAP_COUNT);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  logic signed [2*PCM_W-1:0] prod;
  mac_op_t                   p_op;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_op <= '0;
      done <= 1'b0;
    end else begin
      p_op <= op;
      done <= p_op.valid & p_op.last;
    end
    prod <= sample * coef;
    if (p_op.valid) acc <= (p_op.first ? '0 : acc) + ACC_W'(prod);
  end

  // drop the Q15 fraction, then clamp to 16 bits
  always_comb begin
    acc_sh = acc >>> 15;
    if (acc_sh > SAT_MAX)      result = 16'sh7FFF;
    else if (acc_sh < SAT_MIN) result = -16'sh8000;
    else                       result = acc_sh[PCM_W-1:0];
  end

endmodule

@@ rtl/hbd_mulaw.sv @@
module hbd_mulaw
  import hbd_pkg::*;
(
  input  logic signed [PCM_W-1:0] pcm,
  output logic [CODE_W-1:0]       code
);

  logic        sign;
  logic [16:0] mag_abs;
  logic [14:0] mag;
  logic [2:0]  ex;
  logic [14:0] shifted;

  always_comb begin
    sign    = pcm[PCM_W-1];
    mag_abs = sign ? (17'd0 - {pcm[PCM_W-1], pcm}) : {1'b0, pcm};
    if (mag_abs > ULAW_CLIP) mag_abs = ULAW_CLIP;
    mag = mag_abs[14:0] + ULAW_BIAS;
    // exponent from the highest set bit among bits 14 down to 8
    ex = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (mag[i + 8]) ex = 3'(i + 1);
    end
    // shift amount reaches 10, so widen it past 3 bits
    shifted = mag >> ({1'b0, ex} + 4'd3);
    code = ~{sign, ex, shifted[3:0]};
  end

endmodule

@@ rtl/halfband_decimator_mulaw.sv @@
// Stereo half-band decimate-by-two FIR with G.711 mu-law output. Each input
// item carries one signed 12-bit left/right pair; both are scaled to 16 bits
// and stored in a shared delay-line RAM. Every second item runs the
// TAP_COUNT-tap Q15 filter on both channels with a single multiply-accumulate
// unit, one product per cycle, left pass then right pass, and emits either
// two codes (stereo_mode=1: left, then right with last set) or one mono code
// of the averaged pair. An item that only fills the delay line is taken without
// a stall; a filtering item holds the input stalled through two passes of
// TAP_COUNT reads, each followed by a drain of the MAC pipeline, and a load
// state, set by the MAC unit and the one read port of the delay-line RAM, plus
// any wait for the output register to free up.
// Results wait in an output register, so input items keep flowing while a
// code is stalled. With enable=0 items are taken and dropped. Setting enable,
// or changing stereo_mode while enabled, restarts the filter history from
// zero. Configuration writes are always ready.
module halfband_decimator_mulaw
  import hbd_pkg::*;
#(
  parameter int TAP_COUNT = TAP_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SAMPLE_W-1:0]   left_sample,
  input  logic signed [SAMPLE_W-1:0]   right_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CODE_W-1:0]            ulaw_code,
  output logic                         is_right,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int IDX_W  = $clog2(TAP_COUNT);
  localparam int FILL_W = $clog2(TAP_COUNT + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TAP_COUNT - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(TAP_COUNT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_WAIT = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t              state;
  logic                enable;
  logic                stereo;
  logic [IDX_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    wr_idx_next;
  logic [FILL_W-1:0]   fill;
  logic                phase;
  logic [IDX_W-1:0]    base;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    tap;
  logic                chan;

  logic                in_take;
  logic                cfg_take;
  logic                clear_hist;
  logic                out_take;
  logic                out_free;

  logic                rd_en;
  logic [2*PCM_W-1:0]  rd_data;
  mac_op_t             s0_op;
  mac_op_t             s1_op;
  logic [IDX_W-1:0]    s1_tap;
  logic                s1_ok;
  logic                s1_chan;
  logic signed [PCM_W-1:0] s1_sample;
  logic signed [PCM_W-1:0] s1_coef;
  logic                mac_done;
  logic signed [PCM_W-1:0] mac_result;

  logic signed [PCM_W-1:0] vl;
  logic signed [PCM_W-1:0] vr;
  logic signed [PCM_W-1:0] pend_pcm;
  logic                    pend_valid;
  logic signed [PCM_W:0]   pair_sum;
  logic signed [PCM_W-1:0] enc_in;
  logic [CODE_W-1:0]       enc_code;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign out_take  = out_valid & ~out_stall;
  assign out_free  = ~out_valid | (out_take & ~pend_valid);

  assign clear_hist = cfg_take &
                      (((cfg_index == REG_ENABLE) & cfg_data[0] & ~enable) |
                       ((cfg_index == REG_STEREO) & (cfg_data[0] != stereo) & enable));

  assign wr_idx_next = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;

  hbd_ram #(
    .WIDTH (2 * PCM_W),
    .DEPTH (TAP_COUNT)
  ) u_line (
    .clk   (clk),
    .we    (in_take & enable),
    .waddr (wr_idx),
    .wdata ({16'(right_sample) <<< 4, 16'(left_sample) <<< 4}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_en       = (state == S_MAC);
  assign s0_op.valid = rd_en;
  assign s0_op.first = (tap == '0);
  assign s0_op.last  = (tap == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) s1_op <= '0;
    else     s1_op <= s0_op;
    s1_tap  <= tap;
    s1_ok   <= FILL_W'(rd_addr) < fill;
    s1_chan <= chan;
  end

  // never-written entries read as zero
  assign s1_sample = ~s1_ok ? '0 :
                     (s1_chan ? rd_data[2*PCM_W-1:PCM_W] : rd_data[PCM_W-1:0]);
  assign s1_coef   = coef_at(COEF_IDX_W'(s1_tap));

  hbd_mac #(
    .TAP_COUNT (TAP_COUNT)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .op     (s1_op),
    .sample (s1_sample),
    .coef   (s1_coef),
    .done   (mac_done),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      enable <= 1'b0;
      stereo <= 1'b0;
      wr_idx <= '0;
      fill   <= '0;
      phase  <= 1'b0;
      chan   <= 1'b0;
      tap    <= '0;
    end else begin
      if (cfg_take) begin
        if (cfg_index == REG_ENABLE) enable <= cfg_data[0];
        if (cfg_index == REG_STEREO) stereo <= cfg_data[0];
      end
      if (clear_hist) begin
        wr_idx <= '0;
        fill   <= '0;
        phase  <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take && enable) begin
            wr_idx <= wr_idx_next;
            if (fill != FULL) fill <= fill + 1'b1;
            phase <= ~phase;
            if (phase) begin
              base    <= wr_idx_next;
              rd_addr <= wr_idx_next;
              tap     <= '0;
              chan    <= 1'b0;
              state   <= S_MAC;
            end
          end
        end
        S_MAC: begin
          rd_addr <= (rd_addr == LAST_IDX) ? '0 : rd_addr + 1'b1;
          tap     <= tap + 1'b1;
          if (tap == LAST_IDX) state <= S_WAIT;
        end
        S_WAIT: begin
          if (mac_done) begin
            if (!chan) begin
              vl      <= mac_result;
              chan    <= 1'b1;
              rd_addr <= base;
              tap     <= '0;
              state   <= S_MAC;
            end else begin
              vr    <= mac_result;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pair_sum = {vl[PCM_W-1], vl} + {vr[PCM_W-1], vr};
  assign enc_in   = pend_valid ? pend_pcm : (stereo ? vl : pair_sum[PCM_W:1]);

  hbd_mulaw u_enc (
    .pcm  (enc_in),
    .code (enc_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (state == S_LOAD && out_free) begin
      out_valid  <= 1'b1;
      pend_valid <= stereo;
    end else if (out_take) begin
      out_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
    if (state == S_LOAD && out_free) begin
      ulaw_code <= enc_code;
      is_right  <= 1'b0;
      last      <= ~stereo;
      pend_pcm  <= vr;
    end else if (out_take && pend_valid) begin
      // advance the held right code
      ulaw_code <= enc_code;
      is_right  <= 1'b1;
      last      <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("right code held without a visible left code");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == S_WAIT)
    else $error("MAC finished outside the wait state");

  a_phase_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> !phase)
    else $error("filtering with decimation phase still set");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (fill <= FULL) && (wr_idx <= LAST_IDX) && (rd_addr <= LAST_IDX || state != S_MAC))
    else $error("delay-line index out of range");

  a_not_last_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> pend_valid)
    else $error("non-final code without a following code");
`endif

endmodule

@@ sim/tb_halfband_decimator_mulaw.sv @@
`timescale 1ns / 1ps

module tb_halfband_decimator_mulaw;
  import hbd_pkg::*;

  localparam int TAPS           = 39;
  localparam int FILTER_LATENCY = 2 * TAPS + 8;
  localparam int SETTLE_CYCLES  = FILTER_LATENCY + 24;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int MAX_REPORTS    = 40;
  localparam int MULAW_CLIP     = 32635;
  localparam int MULAW_BIAS     = 'h84;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int TAP_COEF [TAPS] = '{
    -43, 0, 64, 0, -123, 0, 231, 0, -405, 0,
    670, 0, -1081, 0, 1778, 0, -3288, 0, 10378, 16405,
    10378, 0, -3288, 0, 1778, 0, -1081, 0, 670, 0,
    -405, 0, 231, 0, -123, 0, 64, 0, -43
  };

  typedef enum {SAMP_WIDE, SAMP_QUIET, SAMP_CORNER, SAMP_RAIL} sample_kind_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_style_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              right;
    logic              fin;
  } ulaw_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] left_sample = '0;
  logic signed [SAMPLE_W-1:0] right_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [CODE_W-1:0]          ulaw_code;
  logic                       is_right;
  logic                       last;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  halfband_decimator_mulaw dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ulaw_code    (ulaw_code),
    .is_right     (is_right),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0] hist_left  [TAPS];
  logic signed [15:0] hist_right [TAPS];
  int                 hist_pos;
  bit                 odd_item;
  bit                 model_enable;
  bit                 model_stereo;

  ulaw_result_t pending_codes [$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;

  function automatic void clear_history();
    for (int i = 0; i < TAPS; i++) begin
      hist_left[i]  = '0;
      hist_right[i] = '0;
    end
    hist_pos = 0;
    odd_item = 1'b0;
  endfunction

  function automatic int fir_output(input bit right_ch);
    longint acc;
    longint s;
    int     k;
    acc = 0;
    k   = hist_pos;
    for (int n = 0; n < TAPS; n++) begin
      s   = right_ch ? hist_right[k] : hist_left[k];
      acc = acc + s * TAP_COEF[n];
      k   = (k == TAPS - 1) ? 0 : k + 1;
    end
    acc = acc >>> 15;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return int'(acc);
  endfunction

  function automatic logic [CODE_W-1:0] mulaw_code(input int pcm);
    int         mag;
    int         seg;
    logic [7:0] sgn;
    logic [3:0] mant;
    sgn = 8'h00;
    mag = pcm;
    if (mag < 0) begin
      sgn = 8'h80;
      mag = -mag;
    end
    if (mag > MULAW_CLIP) mag = MULAW_CLIP;
    mag = mag + MULAW_BIAS;
    seg = 7;
    while (seg > 0 && ((mag >> (seg + 7)) & 1) == 0) seg--;
    mant = 4'((mag >> (seg + 3)) & 'hF);
    return ~(sgn | 8'(seg << 4) | {4'h0, mant});
  endfunction

  function automatic void predict_pair(input logic signed [SAMPLE_W-1:0] l,
                                       input logic signed [SAMPLE_W-1:0] r);
    int vl;
    int vr;
    int avg;
    if (model_enable) begin
      hist_left[hist_pos]  = {l, 4'b0000};
      hist_right[hist_pos] = {r, 4'b0000};
      hist_pos = (hist_pos == TAPS - 1) ? 0 : hist_pos + 1;
      if (!odd_item) begin
        odd_item = 1'b1;
      end else begin
        odd_item = 1'b0;
        vl = fir_output(1'b0);
        vr = fir_output(1'b1);
        if (model_stereo) begin
          pending_codes.push_back('{mulaw_code(vl), 1'b0, 1'b0});
          pending_codes.push_back('{mulaw_code(vr), 1'b1, 1'b1});
        end else begin
          avg = (vl + vr) >>> 1;
          pending_codes.push_back('{mulaw_code(avg), 1'b0, 1'b1});
        end
      end
    end
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ENABLE: begin
        if (val[0] && !model_enable) clear_history();
        model_enable = val[0];
      end
      REG_STEREO: begin
        if (val[0] != model_stereo) begin
          model_stereo = val[0];
          if (model_enable) clear_history();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_kind_t kind);
    int t;
    logic signed [SAMPLE_W-1:0] v;
    case (kind)
      SAMP_QUIET: begin
        t = $urandom_range(0, 32);
        v = SAMPLE_W'(t - 16);
      end
      SAMP_CORNER: begin
        case ($urandom_range(0, 3))
          0:       v = 2047;
          1:       v = -2048;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      SAMP_RAIL: v = $urandom_range(0, 1) ? 2047 : -2048;
      default:   v = SAMPLE_W'($urandom_range(0, 4095));
    endcase
    return v;
  endfunction

  // rail value that lines up with the sign of tap i-1 once 40 items follow a clear
  function automatic logic signed [SAMPLE_W-1:0] rail_for_tap(input int i, input bit up);
    logic signed [SAMPLE_W-1:0] v;
    if (i == 0 || TAP_COEF[i-1] == 0) v = pick_sample(SAMP_WIDE);
    else if ((TAP_COEF[i-1] > 0) == up) v = 2047;
    else v = -2048;
    return v;
  endfunction

  // wait until every expected code is out and the filter has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pair(l, r);
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_config(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_disabled_and_registers();
    send_pair(2047, -2048);
    send_pair(-2048, 2047);
    send_pair(0, -1);
    // while disabled, a mode write is only stored and clears no history
    write_reg(REG_STEREO, 1'b1);
    write_reg(REG_SPARE_2, 1'b1);
    write_reg(REG_SPARE_3, 1'b1);
    write_reg(REG_SPARE_3, 1'b0);
    send_pair(-1, 1);
    write_reg(REG_ENABLE, 1'b1);
    write_reg(REG_ENABLE, 1'b1);
  endtask

  task automatic test_directed_extremes();
    send_pair(2047, -2048);
    send_pair(-2048, 2047);
    send_pair(0, 0);
    send_pair(-1, 1);
    send_pair(1, -1);
    send_pair(2047, 2047);
    send_pair(-2048, -2048);
    send_pair(1365, -1366);
    // leave the phase odd, then switch to mono while enabled
    send_pair(-1366, 1365);
    write_reg(REG_STEREO, 1'b0);
    send_pair(2047, 2047);
    send_pair(2047, -2048);
    send_pair(-2048, -2048);
    send_pair(100, -100);
    write_reg(REG_ENABLE, 1'b0);
    send_pair(2047, 2047);
    send_pair(-2048, 0);
    write_reg(REG_ENABLE, 1'b1);
    send_pair(-2048, 2047);
    send_pair(-2048, 2047);
  endtask

  // line the samples up with the tap signs so the filter output saturates
  task automatic test_full_scale();
    for (int pass = 0; pass < 2; pass++) begin
      write_reg(REG_STEREO, (pass == 0) ? 1'b1 : 1'b0);
      write_reg(REG_ENABLE, 1'b0);
      write_reg(REG_ENABLE, 1'b1);
      for (int i = 0; i <= TAPS; i++)
        send_pair(rail_for_tap(i, pass == 0), rail_for_tap(i, 1'b0));
    end
  endtask

  task automatic test_random_traffic();
    int           counted;
    int           chunk;
    int           sel;
    bit           new_en;
    bit           new_st;
    sample_kind_t kind_l;
    sample_kind_t kind_r;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      new_en = ($urandom_range(0, 7) != 0);
      new_st = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_STEREO, new_st);
        write_reg(REG_ENABLE, new_en);
      end else begin
        write_reg(REG_ENABLE, new_en);
        write_reg(REG_STEREO, new_st);
      end
      chunk = new_en ? $urandom_range(30, 250) : $urandom_range(3, 12);
      kind_l = SAMP_WIDE;
      kind_r = SAMP_WIDE;
      for (int i = 0; i < chunk; i++) begin
        if (i % 8 == 0) begin
          sel = $urandom_range(0, 9);
          kind_l = (sel < 5) ? SAMP_WIDE : (sel < 7) ? SAMP_QUIET :
                   (sel < 8) ? SAMP_CORNER : SAMP_RAIL;
          kind_r = ($urandom_range(0, 2) == 0) ? sample_kind_t'($urandom_range(0, 3))
                                               : kind_l;
        end
        send_pair(pick_sample(kind_l), pick_sample(kind_r));
        if (model_enable) counted++;
      end
    end
  endtask

  // receiver stall pattern
  stall_style_t stall_style = STALL_NONE;
  int           style_left = 100;
  int           run_left = 0;
  bit           run_stalled = 1'b0;

  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      style_left  <= $urandom_range(50, 400);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      STALL_RUNS: begin
        if (run_left == 0) begin
          run_stalled <= !run_stalled;
          run_left    <= run_stalled ? $urandom_range(1, 5) : $urandom_range(1, 20);
          out_stall   <= !run_stalled;
        end else begin
          run_left  <= run_left - 1;
          out_stall <= run_stalled;
        end
      end
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin : check_codes
    ulaw_result_t head;
    if (!rst && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: unexpected code, expected none, got %02h is_right %0b last %0b",
                   $time, ulaw_code, is_right, last);
        error_count++;
      end else begin
        head = pending_codes.pop_front();
        if (ulaw_code !== head.code) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: ulaw_code mismatch, expected %02h, got %02h",
                     $time, head.code, ulaw_code);
          error_count++;
        end
        if (is_right !== head.right) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: is_right mismatch, expected %0b, got %0b",
                     $time, head.right, is_right);
          error_count++;
        end
        if (last !== head.fin) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: last mismatch, expected %0b, got %0b", $time, head.fin, last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_history();
    model_enable = 1'b0;
    model_stereo = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled_and_registers();
    test_directed_extremes();
    test_full_scale();
    test_random_traffic();
    settle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hbd_pkg.sv
rtl/hbd_ram.sv
rtl/hbd_mac.sv
rtl/hbd_mulaw.sv
rtl/halfband_decimator_mulaw.sv
sim/tb_halfband_decimator_mulaw.sv
